// File: hdl/salc_pkg.sv
// Shared types and constants of the set-associative LRU cache lookup block.
// Used by salc_lru_way, salc_stats and set_assoc_lru_cache_lookup.
`timescale 1ns / 1ps

package salc_pkg;

  // Address layout: byte offset, set index, tag.
  localparam int ADDR_W      = 16;
  localparam int OFFSET_W    = 3;
  localparam int BLOCK_BYTES = 1 << OFFSET_W;
  localparam int SET_W       = 2;
  localparam int NUM_SETS    = 1 << SET_W;
  localparam int TAG_W       = ADDR_W - OFFSET_W - SET_W;

  // Configuration register widths.
  localparam int PENALTY_W = 8;
  localparam int CPW_W     = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  // Access cost and statistics widths.
  localparam int COST_W = 9;
  localparam int CNT_W  = 32;
  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // Reset values of the configuration registers.
  localparam logic [PENALTY_W-1:0] PENALTY_RST = 8'd10;
  localparam logic [CPW_W-1:0]     CPW_RST     = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISS_BASE_PENALTY = 4'd0,
    CFG_CYCLES_PER_WORD   = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              measure;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [SET_W-1:0]  set_index;
    logic [TAG_W-1:0]  tag_value;
    logic [COST_W-1:0] access_cycles;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  cycle_total;
  } out_item_t;

  // Statistics of one transaction, as reported with its result.
  typedef struct packed {
    logic [COST_W-1:0] access_cycles;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  cycle_total;
  } stats_t;

endpackage

// File: hdl/salc_lru_way.sv
// Tag compare and move-to-front reorder for the ways of one set.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_lru_way
  import salc_pkg::*;
#(
  parameter int NUM_WAYS = 2
) (
  input  logic [TAG_W-1:0]                look_tag,
  input  logic [NUM_WAYS-1:0]             way_valid,
  input  logic [NUM_WAYS-1:0][TAG_W-1:0]  way_tags,
  output logic                            hit,
  output logic [NUM_WAYS-1:0]             nxt_valid,
  output logic [NUM_WAYS-1:0][TAG_W-1:0]  nxt_tags
);

  logic [NUM_WAYS-1:0] match;
  logic                seen;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = way_valid[w] && (way_tags[w] == look_tag);
    end
  end

  assign hit = |match;

  // A way shifts back by one if neither it nor any way ahead of it matched. On a miss every
  // way shifts and the last one falls out.
  always_comb begin
    seen         = 1'b0;
    nxt_valid[0] = 1'b1;
    nxt_tags[0]  = look_tag;
    for (int k = 1; k < NUM_WAYS; k++) begin
      seen = seen | match[k-1];
      if (!seen) begin
        nxt_valid[k] = way_valid[k-1];
        nxt_tags[k]  = way_tags[k-1];
      end else begin
        nxt_valid[k] = way_valid[k];
        nxt_tags[k]  = way_tags[k];
      end
    end
  end

endmodule

// File: hdl/salc_stats.sv
// Access cost and saturating hit and cycle counters.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_stats
  import salc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  logic                 hit,
  input  logic                 measure,
  input  logic [PENALTY_W-1:0] miss_base_penalty,
  input  logic [CPW_W-1:0]     cycles_per_word,
  output stats_t               stats
);

  localparam int RAW_W = COST_W + 1;

  logic [CNT_W-1:0]         hit_cnt_r;
  logic [CNT_W-1:0]         hit_cnt_nxt;
  logic [CNT_W-1:0]         cyc_cnt_r;
  logic [CNT_W-1:0]         cyc_cnt_nxt;
  logic [CPW_W+OFFSET_W-1:0] word_cycles;
  logic [RAW_W-1:0]         cost_raw;
  logic [COST_W-1:0]        cost;
  logic [CNT_W:0]           cyc_sum;

  assign word_cycles = {cycles_per_word, {OFFSET_W{1'b0}}};
  assign cost_raw    = RAW_W'(1) + (hit ? RAW_W'(0)
                       : (RAW_W'(miss_base_penalty) + RAW_W'(word_cycles)));
  assign cost        = (cost_raw > {1'b0, COST_MAX}) ? COST_MAX : cost_raw[COST_W-1:0];

  assign cyc_sum = {1'b0, cyc_cnt_r} + (CNT_W + 1)'(cost);

  always_comb begin
    hit_cnt_nxt = hit_cnt_r;
    cyc_cnt_nxt = cyc_cnt_r;
    if (upd && measure) begin
      if (hit && (hit_cnt_r != CNT_MAX)) begin
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
      end
      cyc_cnt_nxt = cyc_sum[CNT_W] ? CNT_MAX : cyc_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r <= '0;
      cyc_cnt_r <= '0;
    end else begin
      hit_cnt_r <= hit_cnt_nxt;
      cyc_cnt_r <= cyc_cnt_nxt;
    end
  end

  assign stats.access_cycles = cost;
  assign stats.hit_total     = hit_cnt_nxt;
  assign stats.cycle_total   = cyc_cnt_nxt;

endmodule

// File: hdl/set_assoc_lru_cache_lookup.sv
// Set-associative cache tag lookup with move-to-front LRU replacement.
// A transaction goes from the input register to the result register; throughput
// one transaction per cycle while the consumer takes the results.
// Reset (synchronous, rst_n low) invalidates every way, clears both counters and
// loads the configuration defaults. No clearing pass is needed.
// Depends on salc_pkg, salc_lru_way and salc_stats.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup
  import salc_pkg::*;
#(
  parameter int NUM_WAYS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Lookup requests.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // Lookup results.
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an index outside the
  // register list is ignored.
  // ---------------------------------------------------------------------------
  logic [PENALTY_W-1:0] penalty_r;
  logic [CPW_W-1:0]     cpw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r <= PENALTY_RST;
      cpw_r     <= CPW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MISS_BASE_PENALTY: penalty_r <= cfg_data[PENALTY_W-1:0];
        CFG_CYCLES_PER_WORD:   cpw_r     <= cfg_data[CPW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. A transaction is held here during its lookup; it moves on
  // whenever the result register is empty or being drained, so an empty input
  // register still takes a transaction while a finished result waits to be taken.
  // ---------------------------------------------------------------------------
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     s1_go;
  logic     in_take;

  assign s1_go    = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Address split. The block size and set count are powers of two, so the
  // offset, set and tag are plain bit fields of the address.
  // ---------------------------------------------------------------------------
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;

  assign cur_set = s1_item_r.address[OFFSET_W +: SET_W];
  assign cur_tag = s1_item_r.address[ADDR_W-1 -: TAG_W];

  // ---------------------------------------------------------------------------
  // Tag store. Each set holds its ways in most-recently-used-first order.
  // Valid bits are cleared by reset; tags are payload and need no reset.
  // The selected set is read, compared and rewritten in the same cycle, so a
  // transaction to the same set in the next cycle sees the updated order.
  // ---------------------------------------------------------------------------
  logic [NUM_WAYS-1:0]            valid_r [NUM_SETS];
  logic [NUM_WAYS-1:0][TAG_W-1:0] tag_r   [NUM_SETS];

  logic                           lk_hit;
  logic [NUM_WAYS-1:0]            lk_nxt_valid;
  logic [NUM_WAYS-1:0][TAG_W-1:0] lk_nxt_tags;

  salc_lru_way #(
    .NUM_WAYS (NUM_WAYS)
  ) u_lru_way (
    .look_tag  (cur_tag),
    .way_valid (valid_r[cur_set]),
    .way_tags  (tag_r[cur_set]),
    .hit       (lk_hit),
    .nxt_valid (lk_nxt_valid),
    .nxt_tags  (lk_nxt_tags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (s1_go) begin
      valid_r[cur_set] <= lk_nxt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      tag_r[cur_set] <= lk_nxt_tags;
    end
  end

  // ---------------------------------------------------------------------------
  // Access cost and statistics. The counters advance only for measured
  // transactions and saturate at their maximum.
  // ---------------------------------------------------------------------------
  stats_t st;

  salc_stats u_stats (
    .clk               (clk),
    .rst_n             (rst_n),
    .upd               (s1_go),
    .hit               (lk_hit),
    .measure           (s1_item_r.measure),
    .miss_base_penalty (penalty_r),
    .cycles_per_word   (cpw_r),
    .stats             (st)
  );

  // ---------------------------------------------------------------------------
  // Result register. It holds one finished transaction until the consumer
  // takes it.
  // ---------------------------------------------------------------------------
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r.hit           <= lk_hit;
      out_data_r.set_index     <= cur_set;
      out_data_r.tag_value     <= cur_tag;
      out_data_r.access_cycles <= st.access_cycles;
      out_data_r.hit_total     <= st.hit_total;
      out_data_r.cycle_total   <= st.cycle_total;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // After a lookup the front way of its set is valid and holds its tag.
  a_front_way_filled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> valid_r[$past(cur_set)][0] && (tag_r[$past(cur_set)][0] == $past(cur_tag)))
    else $error("front way does not hold the tag just looked up");

  // A hit never pays the miss penalty.
  a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && lk_hit |=> out_valid && (out_data.access_cycles == COST_W'(1)))
    else $error("hit reported with a cost other than one cycle");

  // An empty input register always accepts a transaction.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while the input register is empty");

  // With both registers full and the output stalled, the input is closed.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("input open while both registers are full and stalled");

endmodule
